### rtl/sttc_pkg.sv
// Shared types and constants of the stick and throttle command conditioner.
`timescale 1ns / 1ps
package sttc_pkg;

  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam int unsigned NUM_W = 18;
  localparam int unsigned DEN_W = 16;
  localparam int unsigned QUO_W = 10;

  localparam logic [10:0] THR_MIN      = 11'd1000;
  localparam logic [10:0] THR_MAX      = 11'd2000;
  localparam logic [10:0] IDLE_RESET   = 11'd1221;
  localparam logic [6:0]  SDZ_RESET    = 7'd20;
  localparam logic [7:0]  TDZ_RESET    = 8'd10;
  localparam logic [7:0]  TRIG_FULL    = 8'd255;
  localparam logic [7:0]  SLOPE_RAISE  = 8'd99;
  localparam logic [7:0]  SLOPE_LOWER  = 8'd149;
  localparam logic [9:0]  RAMP_SCALE   = 10'd1000;
  localparam logic [7:0]  STICK_BIAS   = 8'd127;
  localparam logic [9:0]  STICK_CENTRE = 10'd500;
  localparam logic [25:0] MAP_MULT     = 26'd66052500;
  localparam int unsigned MAP_SHIFT    = 24;

  typedef enum logic [1:0] {
    REG_STICK_DZ = 2'd0,
    REG_TRIG_DZ  = 2'd1,
    REG_IDLE     = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MAP    = 5'b00010,
    ST_RAISE  = 5'b00100,
    ST_LOWER  = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_e;

  typedef struct packed {
    logic [2:0]        pad;
    logic              height_ok;
    logic [31:0]       now_ms;
    logic [7:0]        lower_trigger;
    logic [7:0]        raise_trigger;
    logic              disarm_button;
    logic              arm_button;
    logic signed [7:0] stick_yaw;
    logic signed [7:0] stick_pitch;
    logic signed [7:0] stick_roll;
    logic              cross_button;
    logic              connected;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        pad;
    logic [10:0]       base_throttle_out;
    logic              hold_out;
    logic              armed_out;
    logic signed [9:0] yaw_cmd;
    logic signed [9:0] pitch_cmd;
    logic signed [9:0] roll_cmd;
    logic [10:0]       throttle_out;
  } out_item_t;

  function automatic logic [10:0] clamp_thr(input logic [10:0] v, input logic [10:0] lo,
                                            input logic [10:0] hi);
    logic [10:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

### rtl/stick_throttle_command_conditioner.sv
// Top level of the stick and throttle command conditioner.
//
// One controller poll enters per input word on the s_axis channel and one
// command word leaves on the m_axis channel. Configuration (stick deadzone,
// trigger deadzone, idle throttle) is written over the APB port at byte
// addresses 0, 4 and 8; the user must write it only while no poll is in
// flight, as the block itself does not enforce this.
// A poll passes through the accepting cycle, the mapping of the three sticks
// through one constant-multiply unit, two ramp interval divisions in one
// shared restoring divider, then a commit cycle.
// The commit fills the output register and returns to idle, raising tready.
// The result sits in an output register; the next poll is taken while it
// waits. If the receiver stalls, the commit cycle holds until the output
// register frees, so nothing is dropped.
// Reset sets throttle 1000, clears armed, hold and cross history, zeroes
// the step times, sets base throttle 1221 and the register defaults.
`timescale 1ns / 1ps
module stick_throttle_command_conditioner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sttc_pkg::APB_AW-1:0]  paddr,
  input  logic [sttc_pkg::APB_DW-1:0]  pwdata,
  output logic [sttc_pkg::APB_DW-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // connected, cross_button, stick_roll, stick_pitch, stick_yaw, arm_button,
  // disarm_button, raise_trigger, lower_trigger, now_ms, height_ok
  input  logic [79:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // throttle_out, roll_cmd, pitch_cmd, yaw_cmd, armed_out, hold_out,
  // base_throttle_out
  output logic [55:0]                  m_axis_tdata
);

  sttc_pkg::state_e   state_q, state_d;
  sttc_pkg::in_item_t in_q;
  sttc_pkg::reg_idx_e reg_idx;

  logic [6:0]  sdz_q;
  logic [7:0]  tdz_q;
  logic [10:0] idle_cfg_q;

  logic [10:0] throttle_q, throttle_d;
  logic        armed_q, armed_d;
  logic        hold_q, hold_d;
  logic        cross_prev_q, cross_prev_d;
  logic [31:0] last_raise_q, last_raise_d;
  logic [31:0] last_lower_q, last_lower_d;
  logic [10:0] base_q, base_d;

  logic [1:0]        map_cnt_q;
  logic signed [9:0] roll_off_q, pitch_off_q, yaw_off_q;
  logic signed [7:0] map_stick;
  logic signed [9:0] map_off;
  logic              map_neg;

  logic                        div_start, div_done;
  logic [sttc_pkg::NUM_W-1:0]  div_num;
  logic [sttc_pkg::DEN_W-1:0]  div_den;
  logic [sttc_pkg::QUO_W-1:0]  div_quot;
  logic [7:0]                  d_span;
  logic [7:0]                  trig_sel, slope_sel;
  logic                        raise_due_q;
  logic [31:0]                 elapsed;

  logic                  out_valid_q;
  sttc_pkg::out_item_t   out_q, out_d;
  logic                  commit;
  logic [10:0]           idle;

  function automatic logic signed [9:0] stick_map(input logic signed [7:0] v,
                                                  input logic [6:0] dz, input logic neg);
    logic signed [7:0] c;
    logic [6:0]        mag;
    logic [8:0]        s;
    logic [7:0]        u;
    logic [33:0]       prod;
    logic [9:0]        mapped;
    c = (v == -8'sd128) ? -8'sd127 : v;
    mag = c[7] ? 7'(-c) : c[6:0];
    if (mag < dz) c = '0;
    s = neg ? 9'(-{c[7], c}) : {c[7], c};
    u = 8'(s + {1'b0, sttc_pkg::STICK_BIAS});
    prod = 34'(u) * 34'(sttc_pkg::MAP_MULT);
    mapped = prod[sttc_pkg::MAP_SHIFT +: 10];
    return 10'(mapped - sttc_pkg::STICK_CENTRE);
  endfunction

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = sttc_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (reg_idx)
      sttc_pkg::REG_STICK_DZ: prdata = sttc_pkg::APB_DW'(sdz_q);
      sttc_pkg::REG_TRIG_DZ:  prdata = sttc_pkg::APB_DW'(tdz_q);
      sttc_pkg::REG_IDLE:     prdata = sttc_pkg::APB_DW'(idle_cfg_q);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sdz_q      <= sttc_pkg::SDZ_RESET;
      tdz_q      <= sttc_pkg::TDZ_RESET;
      idle_cfg_q <= sttc_pkg::IDLE_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        sttc_pkg::REG_STICK_DZ: sdz_q      <= pwdata[6:0];
        sttc_pkg::REG_TRIG_DZ:  tdz_q      <= pwdata[7:0];
        sttc_pkg::REG_IDLE:     idle_cfg_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  assign idle = sttc_pkg::clamp_thr(idle_cfg_q, sttc_pkg::THR_MIN, sttc_pkg::THR_MAX);

  // Stick mapping unit, one stick per cycle
  always_comb begin
    case (map_cnt_q)
      2'd0:    begin map_stick = in_q.stick_roll;  map_neg = 1'b0; end
      2'd1:    begin map_stick = in_q.stick_pitch; map_neg = 1'b1; end
      default: begin map_stick = in_q.stick_yaw;   map_neg = 1'b0; end
    endcase
  end

  assign map_off = stick_map(map_stick, sdz_q, map_neg);

  // Ramp interval operands for the shared divider
  assign d_span    = sttc_pkg::TRIG_FULL - tdz_q;
  assign trig_sel  = (state_q == sttc_pkg::ST_RAISE) ? in_q.lower_trigger : in_q.raise_trigger;
  assign slope_sel = (state_q == sttc_pkg::ST_RAISE) ? sttc_pkg::SLOPE_LOWER
                                                     : sttc_pkg::SLOPE_RAISE;
  assign div_num   = sttc_pkg::NUM_W'(d_span) * sttc_pkg::NUM_W'(sttc_pkg::RAMP_SCALE);
  assign div_den   = sttc_pkg::DEN_W'(8'(trig_sel - tdz_q)) * sttc_pkg::DEN_W'(slope_sel)
                   + sttc_pkg::DEN_W'(d_span);
  assign div_start = ((state_q == sttc_pkg::ST_MAP) && (map_cnt_q == 2'd2))
                   || ((state_q == sttc_pkg::ST_RAISE) && div_done);

  sttc_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign elapsed = in_q.now_ms - last_raise_q;

  // Commit: disconnect, cross edge, arm, ramp, disarm, clamp
  always_comb begin
    logic [10:0] thr;
    thr          = throttle_q;
    armed_d      = armed_q;
    hold_d       = hold_q;
    cross_prev_d = cross_prev_q;
    last_raise_d = last_raise_q;
    last_lower_d = last_lower_q;
    base_d       = base_q;
    if (!in_q.connected) begin
      thr = sttc_pkg::THR_MIN;
    end else begin
      if (armed_q) begin
        if (in_q.cross_button && !cross_prev_q) begin
          if (!hold_q) begin
            if (in_q.height_ok) begin
              hold_d = 1'b1;
              base_d = throttle_q;
            end
          end else begin
            hold_d = 1'b0;
          end
        end
        cross_prev_d = in_q.cross_button;
      end
      if (in_q.arm_button && (thr == sttc_pkg::THR_MIN)) begin
        thr     = idle;
        armed_d = 1'b1;
      end
      if (!hold_d) begin
        if ((in_q.raise_trigger > tdz_q) && (thr >= idle) && raise_due_q) begin
          thr          = sttc_pkg::clamp_thr(thr + 11'd1, idle, sttc_pkg::THR_MAX);
          last_raise_d = in_q.now_ms;
        end
        if ((in_q.lower_trigger > tdz_q) && (thr >= idle)
            && ((in_q.now_ms - last_lower_q) >= 32'(div_quot))) begin
          thr          = sttc_pkg::clamp_thr(thr - 11'd1, idle, sttc_pkg::THR_MAX);
          last_lower_d = in_q.now_ms;
        end
      end
      if (in_q.disarm_button) begin
        thr     = sttc_pkg::THR_MIN;
        armed_d = 1'b0;
        hold_d  = 1'b0;
      end
      thr = sttc_pkg::clamp_thr(thr, sttc_pkg::THR_MIN, sttc_pkg::THR_MAX);
    end
    throttle_d = thr;
  end

  always_comb begin
    out_d                   = '0;
    out_d.throttle_out      = throttle_d;
    out_d.roll_cmd          = in_q.connected ? roll_off_q  : '0;
    out_d.pitch_cmd         = in_q.connected ? pitch_off_q : '0;
    out_d.yaw_cmd           = in_q.connected ? yaw_off_q   : '0;
    out_d.armed_out         = armed_d;
    out_d.hold_out          = hold_d;
    out_d.base_throttle_out = base_d;
  end

  assign commit = (state_q == sttc_pkg::ST_COMMIT) && (!out_valid_q || m_axis_tready);

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      sttc_pkg::ST_IDLE:   if (s_axis_tvalid) state_d = sttc_pkg::ST_MAP;
      sttc_pkg::ST_MAP:    if (map_cnt_q == 2'd2) state_d = sttc_pkg::ST_RAISE;
      sttc_pkg::ST_RAISE:  if (div_done) state_d = sttc_pkg::ST_LOWER;
      sttc_pkg::ST_LOWER:  if (div_done) state_d = sttc_pkg::ST_COMMIT;
      sttc_pkg::ST_COMMIT: if (commit) state_d = sttc_pkg::ST_IDLE;
      default:             state_d = sttc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= sttc_pkg::ST_IDLE;
      map_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      throttle_q   <= sttc_pkg::THR_MIN;
      armed_q      <= 1'b0;
      hold_q       <= 1'b0;
      cross_prev_q <= 1'b0;
      last_raise_q <= '0;
      last_lower_q <= '0;
      base_q       <= sttc_pkg::IDLE_RESET;
    end else begin
      state_q <= state_d;
      if (state_q == sttc_pkg::ST_MAP) map_cnt_q <= map_cnt_q + 2'd1;
      else map_cnt_q <= '0;
      if (commit) begin
        out_valid_q  <= 1'b1;
        throttle_q   <= throttle_d;
        armed_q      <= armed_d;
        hold_q       <= hold_d;
        cross_prev_q <= cross_prev_d;
        last_raise_q <= last_raise_d;
        last_lower_q <= last_lower_d;
        base_q       <= base_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == sttc_pkg::ST_IDLE) && s_axis_tvalid) begin
      in_q <= sttc_pkg::in_item_t'(s_axis_tdata);
    end
    if (state_q == sttc_pkg::ST_MAP) begin
      case (map_cnt_q)
        2'd0:    roll_off_q  <= map_off;
        2'd1:    pitch_off_q <= map_off;
        default: yaw_off_q   <= map_off;
      endcase
    end
    if ((state_q == sttc_pkg::ST_RAISE) && div_done) begin
      raise_due_q <= elapsed >= 32'(div_quot);
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign s_axis_tready = (state_q == sttc_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

### rtl/sttc_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sttc_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sttc_pkg::NUM_W-1:0]   num_i,
  input  logic [sttc_pkg::DEN_W-1:0]   den_i,
  output logic                         done_o,
  output logic [sttc_pkg::QUO_W-1:0]   quot_o
);

  localparam int unsigned DivW = sttc_pkg::DEN_W + sttc_pkg::QUO_W - 1;
  localparam int unsigned CntW = $clog2(sttc_pkg::QUO_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [sttc_pkg::NUM_W-1:0]  rem_q, rem_d;
  logic [DivW-1:0]             div_q, div_d;
  logic [sttc_pkg::QUO_W-1:0]  quot_q, quot_d;
  logic                        fits;

  assign fits = DivW'(rem_q) >= div_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(sttc_pkg::QUO_W - 1);
      rem_d  = num_i;
      div_d  = {den_i, (sttc_pkg::QUO_W - 1)'(0)};
      quot_d = '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_d = rem_q - sttc_pkg::NUM_W'(div_q);
      end
      quot_d = {quot_q[sttc_pkg::QUO_W-2:0], fits};
      div_d  = div_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    div_q  <= div_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
